// ----- src/clel_pkg.sv -----
// ----------------------------------------------------------------------------
// clel_pkg: shared types and constants of the circular elimination list
// Beat structs of both channels, the internal command format, the stored
// entry and the back-end state encoding.
// ----------------------------------------------------------------------------
package clel_pkg;

	localparam int POSITION_W = 7;
	localparam int OPERAND_W = 32;
	localparam int TAG_W = 16;
	localparam int COUNT_OUT_W = 7;
	localparam int CURSOR_OUT_W = 6;
	// cursor plus step before the modulo
	localparam int DIVIDEND_W = OPERAND_W + 1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic                  action;
		logic [POSITION_W-1:0] position;
		logic [OPERAND_W-1:0]  operand;
		logic [TAG_W-1:0]      tag;
	} in_t;

	typedef struct packed {
		status_t                 status;
		logic [OPERAND_W-1:0]    removed_value;
		logic [TAG_W-1:0]        removed_tag;
		logic [COUNT_OUT_W-1:0]  count;
		logic                    is_empty;
		logic [CURSOR_OUT_W-1:0] cursor_pos;
	} out_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [POSITION_W-1:0] position;
		logic [OPERAND_W-1:0]  operand;
		logic [TAG_W-1:0]      tag;
	} cmd_t;

	typedef struct packed {
		logic [OPERAND_W-1:0] value;
		logic [TAG_W-1:0]     tag;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_RD,
		BK_CAP,
		BK_SHIFT
	} bk_state_t;

endpackage

// ----- src/circular_elimination_list.sv -----
// ----------------------------------------------------------------------------
// circular_elimination_list: packed list with a circular elimination cursor
// Inserts entries at a position, or steps the cursor and removes an entry.
// ----------------------------------------------------------------------------
// Input side is a queue: a beat is taken when push is high and full is low.
// Up to two commands wait ahead of the execution unit, so the sender keeps
// going while a result is still unread.
// Result side is a queue too: while empty is low the result beat is on the
// result port, and it leaves when pop is high. A stalled receiver holds the
// execution unit once the result slot is taken; commands still queue up.
// Each command gives exactly one result beat.
// Execution of a command:
//   refused command: its result is loaded without leaving the idle state
//   insert: entries from position up move up by one, one entry moved per
//   cycle, then the new entry is written at position
//   remove: the remainder unit reduces cursor plus step modulo count, the
//   entry there is read and captured, and the entries behind it move down
// Reset clears count and cursor; list contents need no clearing, a read
// only ever touches entries that were written.
// ----------------------------------------------------------------------------
module circular_elimination_list import clel_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	clel_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	clel_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

// ----- src/clel_front.sv -----
// ----------------------------------------------------------------------------
// clel_front: input side of the list
// Takes input beats, turns them into commands and holds up to two of them
// for the back end.
// ----------------------------------------------------------------------------
module clel_front import clel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;
	cmd_t       cmd_new;

	always_comb begin
		cmd_new.kind = item.action ? CMD_REMOVE : CMD_INSERT;
		cmd_new.position = item.position;
		cmd_new.operand = item.operand;
		cmd_new.tag = item.tag;
	end

	assign full = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ----- src/clel_div.sv -----
// ----------------------------------------------------------------------------
// clel_div: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives the remainder only.
// ----------------------------------------------------------------------------
module clel_div import clel_pkg::*; #(
	parameter int DIVW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVW-1:0]       divisor,
	output logic                  done,
	output logic [DIVW-1:0]       remainder
);

	localparam int CNTW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVW-1:0]       dvs_q;
	logic [DIVW-1:0]       rem_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVW:0]         trial;
	logic [DIVW:0]         diff;
	logic                  fits;

	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign fits = (trial >= {1'b0, dvs_q});
	assign diff = trial - {1'b0, dvs_q};
	assign done = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIVW-1:0] : trial[DIVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/clel_back.sv -----
// ----------------------------------------------------------------------------
// clel_back: execution side of the list
// Holds the entry memory, count and cursor; runs inserts and removes with a
// one-entry-per-cycle shift and keeps the finished result in an output slot.
// ----------------------------------------------------------------------------
module clel_back import clel_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input  logic pop,
	output out_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	entry_t          mem [CAPACITY];
	entry_t          rdata_s1;
	logic            rvalid_s1;
	logic [AW-1:0]   raddr_s1;

	bk_state_t       state_q;
	bk_state_t       state_d;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   cursor_q;
	logic [AW-1:0]   raddr_q;
	logic [CW-1:0]   reads_left_q;
	logic            op_ins_q;
	logic [AW-1:0]   pos_q;
	logic [OPERAND_W-1:0] operand_q;
	logic [TAG_W-1:0]     tag_q;
	logic [AW-1:0]   rem_q;
	entry_t          removed_q;
	out_t            res_q;
	logic            res_valid_q;

	logic            start;
	logic            ins_full;
	logic            ins_bad;
	logic            rem_empty;
	logic            issue;
	logic            shift_done;
	logic [AW-1:0]   cur_eff;
	logic            div_start;
	logic            div_done;
	logic [CW-1:0]   div_rem;
	logic [DIVIDEND_W-1:0] dividend;

	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	entry_t          wdata;
	logic            res_load;
	status_t         res_status;
	entry_t          res_entry;
	logic [CW-1:0]   res_count;
	logic [AW-1:0]   res_cursor;
	logic [31:0]     count_ext;
	logic [31:0]     cursor_ext;
	logic [AW-1:0]   cursor_after;
	logic [CW-1:0]   count_m1;

	assign start = (state_q == BK_IDLE) && cmd_valid && !res_valid_q;
	assign cmd_pop = start;
	assign ins_full = (count_q == CW'(CAPACITY));
	assign ins_bad = (32'(cmd.position) > 32'(count_q));
	assign rem_empty = (count_q == '0);
	assign issue = (state_q == BK_SHIFT) && (reads_left_q != '0);
	assign shift_done = (state_q == BK_SHIFT) && (reads_left_q == '0) && !rvalid_s1;
	assign cur_eff = (32'(cursor_q) >= 32'(count_q)) ? '0 : cursor_q;
	assign dividend = DIVIDEND_W'(cur_eff) + DIVIDEND_W'(cmd.operand);
	assign div_start = start && (cmd.kind == CMD_REMOVE) && !rem_empty;
	assign count_m1 = count_q - CW'(1);
	assign cursor_after = (CW'(rem_q) == count_m1) ? '0 : rem_q;

	clel_div #(
		.DIVW(CW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(count_q),
		.done(div_done),
		.remainder(div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start) begin
					if (cmd.kind == CMD_INSERT) begin
						if (!ins_full && !ins_bad) begin
							state_d = BK_SHIFT;
						end
					end else if (!rem_empty) begin
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_RD;
				end
			end
			BK_RD: state_d = BK_CAP;
			BK_CAP: state_d = BK_SHIFT;
			BK_SHIFT: begin
				if (shift_done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// memory port and result selection
	always_comb begin
		raddr = (state_q == BK_RD) ? rem_q : raddr_q;
		we = 1'b0;
		waddr = raddr_s1;
		wdata = rdata_s1;
		if (rvalid_s1) begin
			we = 1'b1;
			waddr = op_ins_q ? raddr_s1 + AW'(1) : raddr_s1 - AW'(1);
		end else if (shift_done && op_ins_q) begin
			we = 1'b1;
			waddr = pos_q;
			wdata.value = operand_q;
			wdata.tag = tag_q;
		end

		res_load = 1'b0;
		res_status = ST_OK;
		res_entry = '0;
		res_count = count_q;
		res_cursor = cursor_q;
		if (start) begin
			if (cmd.kind == CMD_INSERT) begin
				if (ins_full) begin
					res_load = 1'b1;
					res_status = ST_FULL;
				end else if (ins_bad) begin
					res_load = 1'b1;
					res_status = ST_BADPOS;
				end
			end else if (rem_empty) begin
				res_load = 1'b1;
				res_status = ST_EMPTY;
			end
		end else if (shift_done) begin
			res_load = 1'b1;
			if (op_ins_q) begin
				res_count = count_q + CW'(1);
			end else begin
				res_count = count_m1;
				res_cursor = cursor_after;
				res_entry = removed_q;
			end
		end
		count_ext = 32'(res_count);
		cursor_ext = 32'(res_cursor);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
		raddr_s1 <= raddr_q;
	end

	// command payload and shift bookkeeping
	always_ff @(posedge clk) begin
		if (start) begin
			op_ins_q <= (cmd.kind == CMD_INSERT);
			pos_q <= AW'(cmd.position);
			operand_q <= cmd.operand;
			tag_q <= cmd.tag;
			raddr_q <= AW'(count_m1);
			reads_left_q <= count_q - CW'(cmd.position);
		end else if (state_q == BK_CAP) begin
			removed_q <= rdata_s1;
			raddr_q <= rem_q + AW'(1);
			reads_left_q <= count_m1 - CW'(rem_q);
		end else if (issue) begin
			raddr_q <= op_ins_q ? raddr_q - AW'(1) : raddr_q + AW'(1);
			reads_left_q <= reads_left_q - CW'(1);
		end
		if (div_done) begin
			rem_q <= AW'(div_rem);
		end
		if (res_load) begin
			res_q.status <= res_status;
			res_q.removed_value <= res_entry.value;
			res_q.removed_tag <= res_entry.tag;
			res_q.count <= count_ext[COUNT_OUT_W-1:0];
			res_q.is_empty <= (res_count == '0);
			res_q.cursor_pos <= cursor_ext[CURSOR_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			cursor_q <= '0;
			rvalid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvalid_s1 <= issue;
			if (shift_done) begin
				count_q <= res_count;
				cursor_q <= res_cursor;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !res_valid_q;
	assign result = res_q;

endmodule

// ----- sim/clel_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clel_checker: result checker for the circular elimination list
// Watches both beat channels. Every accepted command runs through a local
// model of the list and cursor; the predicted result beat is queued and
// compared field by field with the next result beat that leaves the block.
// ----------------------------------------------------------------------------
module clel_checker import clel_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  in_t  item,
	input  logic empty,
	input  logic pop,
	input  out_t result,
	output int   mismatches,
	output int   pending
);

	entry_t slots[CAPACITY];
	int     list_len;
	int     cur;
	out_t   expected_results[$];

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic apply_list_op(input in_t op, output out_t res);
		logic [63:0] sum;
		int          j;
		res = '0;
		if (op.action == CMD_INSERT) begin
			if (list_len >= CAPACITY) begin
				res.status = ST_FULL;
			end else if (op.position > list_len) begin
				res.status = ST_BADPOS;
			end else begin
				for (j = list_len; j > op.position; j--)
					slots[j] = slots[j-1];
				slots[op.position] = '{value: op.operand, tag: op.tag};
				list_len++;
				res.status = ST_OK;
			end
		end else if (list_len == 0) begin
			res.status = ST_EMPTY;
		end else begin
			if (cur >= list_len)
				cur = 0;
			// step may be huge, so do the modulo on a wide sum
			sum = 64'(cur) + 64'(op.operand);
			cur = int'(sum % 64'(list_len));
			res.removed_value = slots[cur].value;
			res.removed_tag = slots[cur].tag;
			list_len--;
			for (j = cur; j < list_len; j++)
				slots[j] = slots[j+1];
			if (cur == list_len)
				cur = 0;
			res.status = ST_OK;
		end
		res.count = 7'(list_len);
		res.is_empty = (list_len == 0);
		res.cursor_pos = 6'(cur);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		out_t prediction;
		if (!arst_n) begin
			expected_results.delete();
			list_len = 0;
			cur = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			// a result beat always belongs to an older command, so compare first
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %p",
						$time, result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("removed_value", want.removed_value, result.removed_value);
					check_field("removed_tag", 32'(want.removed_tag), 32'(result.removed_tag));
					check_field("count", 32'(want.count), 32'(result.count));
					check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
					check_field("cursor_pos", 32'(want.cursor_pos), 32'(result.cursor_pos));
				end
			end
			if (push && !full) begin
				apply_list_op(item, prediction);
				expected_results.push_back(prediction);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the circular elimination list
// Drives a short directed sequence and then random fill, drain and mixed
// phases of inserts and removes, with random gaps and stalls on both sides
// and one long receiver hold-off. Checking is done by clel_checker.
// ----------------------------------------------------------------------------
module tb;
	import clel_pkg::*;

	localparam int CAPACITY = 64;
	localparam int NUM_OPS = 650;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_START = 3000;
	localparam int HOLD_END = 3600;
	localparam int POP_STEADY_START = 9000;
	localparam int POP_STEADY_END = 14000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic empty;
	logic pop;
	out_t result;
	int   mismatches;
	int   pending;

	int   ops_sent;
	int   list_len;
	bit   steady_send;

	circular_elimination_list #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	clel_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_beat(input in_t b);
		if (!steady_send && $urandom_range(99) < 17) begin
			@(negedge clk);
			push <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		ops_sent++;
		// track the length only to steer the random phases
		if (b.action == CMD_INSERT) begin
			if (list_len < CAPACITY && b.position <= list_len)
				list_len++;
		end else if (list_len > 0) begin
			list_len--;
		end
	endtask

	task automatic issue(input cmd_kind_t kind, input int position,
		input logic [31:0] operand, input logic [15:0] tag);
		in_t b;
		b.action = kind;
		b.position = 7'(position);
		b.operand = operand;
		b.tag = tag;
		send_beat(b);
	endtask

	task automatic random_list_op(input bit grow);
		in_t b;
		int  pick;
		b.tag = 16'($urandom);
		b.operand = $urandom;
		b.position = 7'($urandom_range(127));
		if ($urandom_range(99) < (grow ? 85 : 15)) begin
			b.action = CMD_INSERT;
			pick = $urandom_range(9);
			if (pick == 1)
				b.position = '0;
			else if (pick == 2)
				b.position = 7'(list_len);
			else if (pick > 2)
				b.position = 7'($urandom_range(list_len));
		end else begin
			b.action = CMD_REMOVE;
			pick = $urandom_range(9);
			if (pick < 4)
				b.operand = $urandom_range(2 * list_len + 1);
			else if (pick == 4)
				b.operand = '0;
			else if (pick == 5)
				b.operand = '1;
		end
		send_beat(b);
	endtask

	// receiver: random stalls, one long hold-off, one stretch with no stalls
	initial begin
		int cyc;
		cyc = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_START && cyc < HOLD_END)
				pop <= 1'b0;
			else if (cyc >= POP_STEADY_START && cyc < POP_STEADY_END)
				pop <= 1'b1;
			else
				pop <= ($urandom_range(99) >= 17);
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int target;
		int phase;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		ops_sent = 0;
		list_len = 0;
		steady_send = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: refusals, field extremes, front, middle and end inserts
		issue(CMD_REMOVE, 0, 32'd5, 16'h0000);
		issue(CMD_INSERT, 1, 32'd1, 16'h0001);
		issue(CMD_INSERT, 127, '1, '1);
		issue(CMD_INSERT, 0, 32'hFFFF_FFFF, 16'hFFFF);
		issue(CMD_INSERT, 1, 32'h0000_0000, 16'h0000);
		issue(CMD_INSERT, 0, 32'h1234_5678, 16'hA5A5);
		issue(CMD_INSERT, 1, 32'h89AB_CDEF, 16'h5A5A);
		issue(CMD_INSERT, 4, 32'hDEAD_BEEF, 16'h1234);
		issue(CMD_INSERT, 2, 32'h0000_0001, 16'h8000);
		issue(CMD_INSERT, 64, 32'h5555_5555, 16'h7FFF);
		issue(CMD_INSERT, 7, 32'hAAAA_AAAA, 16'h0F0F);
		issue(CMD_REMOVE, 0, 32'h0000_0000, 16'h0000);
		issue(CMD_REMOVE, 127, 32'hFFFF_FFFF, 16'hFFFF);
		issue(CMD_REMOVE, 0, 32'h8000_0000, 16'h0000);
		issue(CMD_REMOVE, 0, 32'd1, 16'h0000);
		while (list_len > 0)
			issue(CMD_REMOVE, 0, $urandom, 16'h0000);
		issue(CMD_REMOVE, 0, 32'd3, 16'h0000);

		// random: walk the length toward targets, first full then empty
		phase = 0;
		while (ops_sent < NUM_OPS) begin
			if (phase == 0)
				target = CAPACITY;
			else if (phase == 1)
				target = 0;
			else if ($urandom_range(9) < 3)
				target = CAPACITY;
			else if ($urandom_range(6) < 3)
				target = 0;
			else
				target = $urandom_range(CAPACITY - 1, 1);
			phase++;
			while (list_len != target && ops_sent < NUM_OPS) begin
				steady_send = (ops_sent >= 250 && ops_sent < 400);
				random_list_op(list_len < target);
			end
			// push past the ends to hit full and empty refusals
			if (target == CAPACITY || target == 0)
				repeat (2) random_list_op(target == CAPACITY);
		end
		@(negedge clk);
		push <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- circular_elimination_list.f -----
src/clel_pkg.sv
src/clel_front.sv
src/clel_div.sv
src/clel_back.sv
src/circular_elimination_list.sv
sim/clel_checker.sv
sim/tb.sv
